// ===== sv/gaps_pkg.sv =====
package gaps_pkg;

    localparam int MaxDim    = 32;
    localparam int Cells     = MaxDim * MaxDim;
    localparam int HeapDepth = 4096;
    localparam int CellW     = $clog2(Cells);
    localparam int CoordW    = $clog2(MaxDim);
    localparam int DimW      = 6;
    localparam int CostW     = 11;
    localparam int KeyW      = CostW + CellW;
    localparam int HIdxW     = $clog2(HeapDepth);
    localparam int HCntW     = HIdxW + 1;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [3:0] {
        S_RCLR, S_IDLE, S_CLR, S_INIT, S_LOOP, S_POPW, S_CHK,
        S_NB, S_NB2, S_PUSHW, S_BP, S_BP2, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        H_IDLE, H_PUSH_RD, H_PUSH_CMP, H_WR_FIN, H_POP_LAST, H_POP_RDC, H_POP_CMP
    } t_hstate;

    typedef struct packed {
        logic            clear;
        logic            push;
        logic            pop;
        logic [KeyW-1:0] key;
    } t_heap_cmd;

    typedef struct packed {
        logic             busy;
        logic [HCntW-1:0] count;
        logic [KeyW-1:0]  top;
    } t_heap_stat;

    function automatic logic [CoordW-1:0] absdiff(input logic [CoordW-1:0] a,
                                                  input logic [CoordW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [CoordW:0] manh(input logic [CellW-1:0] node,
                                             input logic [CoordW-1:0] gr,
                                             input logic [CoordW-1:0] gc);
        return {1'b0, absdiff(node[CellW-1:CoordW], gr)}
             + {1'b0, absdiff(node[CoordW-1:0], gc)};
    endfunction

    function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
        if (v == '0) begin
            return DimW'(1);
        end else if (v > DimW'(MaxDim)) begin
            return DimW'(MaxDim);
        end
        return v;
    endfunction

endpackage

// ===== sv/gaps_in_if.sv =====
interface gaps_in_if;
    import gaps_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [CoordW-1:0] cell_row;
    logic [CoordW-1:0] cell_col;
    logic              blocked;
    logic [CoordW-1:0] start_row;
    logic [CoordW-1:0] start_col;
    logic [CoordW-1:0] goal_row;
    logic [CoordW-1:0] goal_col;
    logic [CellW-1:0]  path_index;

    modport source (output valid, func, cell_row, cell_col, blocked, start_row, start_col,
                    goal_row, goal_col, path_index, input ready);
    modport sink (input valid, func, cell_row, cell_col, blocked, start_row, start_col,
                  goal_row, goal_col, path_index, output ready);
endinterface

// ===== sv/gaps_out_if.sv =====
interface gaps_out_if;
    import gaps_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [CostW-1:0]  path_length;
    logic              entry_valid;
    logic [CoordW-1:0] path_row;
    logic [CoordW-1:0] path_col;

    modport source (output valid, found, path_length, entry_valid, path_row, path_col,
                    input ready);
    modport sink (input valid, found, path_length, entry_valid, path_row, path_col,
                  output ready);
endinterface

// ===== sv/gaps_heap.sv =====
module gaps_heap (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gaps_pkg::t_heap_cmd   i_cmd,
    output gaps_pkg::t_heap_stat  o_stat
);
    import gaps_pkg::*;

    logic [KeyW-1:0] mem [HeapDepth];

    t_hstate           r_state, n_state;
    logic [HCntW-1:0]  r_cnt, n_cnt;
    logic [HIdxW-1:0]  r_i, n_i;
    logic [KeyW-1:0]   r_key, n_key;
    logic [KeyW-1:0]   r_top, n_top;
    logic [KeyW-1:0]   r_rd0, r_rd1;
    logic [HIdxW-1:0]  rd_a0, rd_a1, wa;
    logic [KeyW-1:0]   wd, mv;
    logic              we;
    logic [HIdxW-1:0]  p, m;
    logic [HCntW-1:0]  lc, rc, dec;

    always_ff @(posedge i_clk) begin
        r_rd0 <= mem[rd_a0];
        r_rd1 <= mem[rd_a1];
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_i   <= n_i;
        r_key <= n_key;
        r_top <= n_top;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_key   = r_key;
        n_top   = r_top;
        we      = 1'b0;
        wa      = r_i;
        wd      = r_key;
        dec     = r_cnt - HCntW'(1);
        p       = (r_i - HIdxW'(1)) >> 1;
        lc      = {r_i, 1'b1};
        rc      = lc + HCntW'(1);
        rd_a0   = '0;
        rd_a1   = dec[HIdxW-1:0];
        m       = r_i;
        mv      = r_key;
        case (r_state)
            H_IDLE: begin
                if (i_cmd.clear) begin
                    n_cnt = '0;
                end else if (i_cmd.push) begin
                    n_cnt = r_cnt + HCntW'(1);
                    n_i   = r_cnt[HIdxW-1:0];
                    n_key = i_cmd.key;
                    if (r_cnt == '0) begin
                        we = 1'b1;
                        wa = '0;
                        wd = i_cmd.key;
                    end else begin
                        n_state = H_PUSH_RD;
                    end
                end else if (i_cmd.pop) begin
                    n_cnt   = dec;
                    n_state = H_POP_LAST;
                end
            end
            H_PUSH_RD: begin
                rd_a0   = p;
                n_state = H_PUSH_CMP;
            end
            H_PUSH_CMP: begin
                we = 1'b1;
                if (r_rd0 <= r_key) begin
                    n_state = H_IDLE;
                end else begin
                    wd  = r_rd0;
                    n_i = p;
                    n_state = (p == '0) ? H_WR_FIN : H_PUSH_RD;
                end
            end
            H_WR_FIN: begin
                we      = 1'b1;
                n_state = H_IDLE;
            end
            H_POP_LAST: begin
                n_top = r_rd0;
                n_key = r_rd1;
                n_i   = '0;
                n_state = (r_cnt == '0) ? H_IDLE : H_POP_RDC;
            end
            H_POP_RDC: begin
                rd_a0   = lc[HIdxW-1:0];
                rd_a1   = rc[HIdxW-1:0];
                n_state = H_POP_CMP;
            end
            H_POP_CMP: begin
                if (lc < r_cnt && r_rd0 < mv) begin
                    m  = lc[HIdxW-1:0];
                    mv = r_rd0;
                end
                if (rc < r_cnt && r_rd1 < mv) begin
                    m  = rc[HIdxW-1:0];
                    mv = r_rd1;
                end
                we = 1'b1;
                if (m == r_i) begin
                    n_state = H_IDLE;
                end else begin
                    wd      = mv;
                    n_i     = m;
                    n_state = H_POP_RDC;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    assign o_stat.busy  = (r_state != H_IDLE);
    assign o_stat.count = r_cnt;
    assign o_stat.top   = r_top;

endmodule

// ===== sv/grid_astar_path_search.sv =====
// One request at a time.
// Search: a cost clear over every cell, then per expanded cell a heap pop
// with its sift-down and a check, and per neighbor a bounds test, a block
// and cost test and a push with its sift-up, then a trace back over the path cells.
// Synchronous active-low reset; after reset a pass clears the occupancy map,
// during which no request is taken.
module grid_astar_path_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [gaps_pkg::DimW-1:0]    i_cfg_data,
    gaps_in_if.sink                      i_in,
    gaps_out_if.source                   o_out
);
    import gaps_pkg::*;

    logic               blk_mem  [Cells];
    logic [CostW:0]     cost_mem [Cells];
    logic [1:0]         came_mem [Cells];
    logic [CellW-1:0]   path_mem [Cells];

    t_state             r_state, n_state;
    logic [DimW-1:0]    r_rows, r_cols;
    logic [CellW-1:0]   r_cnt, n_cnt;
    logic [CoordW-1:0]  r_gr, n_gr, r_gc, n_gc;
    logic [CellW-1:0]   r_s, n_s, r_cell, n_cell, r_n, n_n, r_k, n_k, r_cur, n_cur;
    logic [CellW-1:0]   r_idx, n_idx;
    logic [CostW-1:0]   r_g, n_g, r_len, n_len, r_length, n_length;
    logic [1:0]         r_d, n_d;
    logic               r_found, n_found, r_ev, n_ev;
    logic               r_ov, n_ov, r_of, n_of, r_oev, n_oev;
    logic [CostW-1:0]   r_olen, n_olen;
    logic [CoordW-1:0]  r_orow, n_orow, r_ocol, n_ocol;

    logic               r_blk_rd;
    logic [CostW:0]     r_cost_rd;
    logic [1:0]         r_came_rd;
    logic [CellW-1:0]   r_path_rd;

    logic               blk_we, blk_wd, cost_we, came_we, path_we;
    logic [CellW-1:0]   blk_wa, blk_ra, cost_wa, cost_ra, came_ra;
    logic [CostW:0]     cost_wd;

    t_heap_cmd          hcmd;
    t_heap_stat         hstat;

    logic [DimW-1:0]    rows, cols;
    logic               acc, nb_ok;
    logic [CoordW-1:0]  rr, cc, pr, pc;
    logic [CellW-1:0]   nn;
    logic [CoordW:0]    h;
    logic [CostW-1:0]   f, ng;

    gaps_heap u_heap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (hcmd),
        .o_stat (hstat)
    );

    always_ff @(posedge i_clk) begin
        r_blk_rd  <= blk_mem[blk_ra];
        r_cost_rd <= cost_mem[cost_ra];
        r_came_rd <= came_mem[came_ra];
        r_path_rd <= path_mem[n_idx];
        if (blk_we) begin
            blk_mem[blk_wa] <= blk_wd;
        end
        if (cost_we) begin
            cost_mem[cost_wa] <= cost_wd;
        end
        if (came_we) begin
            came_mem[r_n] <= r_d;
        end
        if (path_we) begin
            path_mem[r_k] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RCLR;
            r_rows   <= DimW'(MaxDim);
            r_cols   <= DimW'(MaxDim);
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_length <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
            r_length <= n_length;
            r_ov     <= n_ov;
            if (i_cfg_we && i_cfg_idx == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
        end
        r_gr   <= n_gr;
        r_gc   <= n_gc;
        r_s    <= n_s;
        r_cell <= n_cell;
        r_n    <= n_n;
        r_k    <= n_k;
        r_cur  <= n_cur;
        r_idx  <= n_idx;
        r_g    <= n_g;
        r_len  <= n_len;
        r_d    <= n_d;
        r_ev   <= n_ev;
        r_of   <= n_of;
        r_oev  <= n_oev;
        r_olen <= n_olen;
        r_orow <= n_orow;
        r_ocol <= n_ocol;
    end

    assign rows = eff_dim(r_rows);
    assign cols = eff_dim(r_cols);
    assign acc  = i_in.valid && (r_state == S_IDLE);
    assign rr   = r_cell[CellW-1:CoordW];
    assign cc   = r_cell[CoordW-1:0];
    assign pr   = r_cur[CellW-1:CoordW];
    assign pc   = r_cur[CoordW-1:0];

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_gr     = r_gr;
        n_gc     = r_gc;
        n_s      = r_s;
        n_cell   = r_cell;
        n_n      = r_n;
        n_k      = r_k;
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_g      = r_g;
        n_len    = r_len;
        n_d      = r_d;
        n_found  = r_found;
        n_length = r_length;
        n_ev     = r_ev;
        n_ov     = r_ov && !o_out.ready;
        n_of     = r_of;
        n_oev    = r_oev;
        n_olen   = r_olen;
        n_orow   = r_orow;
        n_ocol   = r_ocol;
        blk_we   = 1'b0;
        blk_wa   = r_cnt;
        blk_wd   = 1'b0;
        cost_we  = 1'b0;
        cost_wa  = r_cnt;
        cost_wd  = '0;
        came_we  = 1'b0;
        came_ra  = r_cur;
        path_we  = 1'b0;
        hcmd     = '0;
        nb_ok    = 1'b0;
        nn       = r_cell;
        h        = manh(hstat.top[CellW-1:0], r_gr, r_gc);
        f        = hstat.top[KeyW-1:CellW];
        ng       = r_g + CostW'(1);
        case (r_d)
            DIR_UP: begin
                nb_ok = (rr != '0);
                nn    = {rr - CoordW'(1), cc};
            end
            DIR_DOWN: begin
                nb_ok = ({1'b0, rr} + DimW'(1)) < rows;
                nn    = {rr + CoordW'(1), cc};
            end
            DIR_LEFT: begin
                nb_ok = (cc != '0);
                nn    = {rr, cc - CoordW'(1)};
            end
            DIR_RIGHT: begin
                nb_ok = ({1'b0, cc} + DimW'(1)) < cols;
                nn    = {rr, cc + CoordW'(1)};
            end
            default: nb_ok = 1'b0;
        endcase
        blk_ra   = nn;
        cost_ra  = nn;
        case (r_state)
            S_RCLR: begin
                blk_we = 1'b1;
                n_cnt  = r_cnt + CellW'(1);
                if (r_cnt == CellW'(Cells - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_ev    = 1'b0;
                    n_idx   = i_in.path_index;
                    n_state = S_OUT;
                    case (i_in.func)
                        FUNC_WRITE: begin
                            blk_we = 1'b1;
                            blk_wa = {i_in.cell_row, i_in.cell_col};
                            blk_wd = i_in.blocked;
                        end
                        FUNC_SEARCH: begin
                            n_found  = 1'b0;
                            n_length = '0;
                            n_gr     = i_in.goal_row;
                            n_gc     = i_in.goal_col;
                            n_s      = {i_in.start_row, i_in.start_col};
                            n_cnt    = '0;
                            if ({1'b0, i_in.start_row} < rows && {1'b0, i_in.start_col} < cols
                                && {1'b0, i_in.goal_row} < rows
                                && {1'b0, i_in.goal_col} < cols) begin
                                n_state = S_CLR;
                            end
                        end
                        FUNC_READ: begin
                            n_ev = {1'b0, i_in.path_index} < r_length;
                        end
                        default: n_ev = 1'b0;
                    endcase
                end
            end
            S_CLR: begin
                cost_we    = 1'b1;
                hcmd.clear = 1'b1;
                n_cnt      = r_cnt + CellW'(1);
                if (r_cnt == CellW'(Cells - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                cost_we   = 1'b1;
                cost_wa   = r_s;
                cost_wd   = {1'b1, CostW'(0)};
                hcmd.push = 1'b1;
                hcmd.key  = {CostW'(manh(r_s, r_gr, r_gc)), r_s};
                n_state   = S_LOOP;
            end
            S_LOOP: begin
                if (!hstat.busy) begin
                    if (hstat.count == '0) begin
                        n_state = S_OUT;
                    end else begin
                        hcmd.pop = 1'b1;
                        n_state  = S_POPW;
                    end
                end
            end
            S_POPW: begin
                cost_ra = hstat.top[CellW-1:0];
                if (!hstat.busy) begin
                    n_cell  = hstat.top[CellW-1:0];
                    n_g     = (f >= CostW'(h)) ? f - CostW'(h) : '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_cost_rd[CostW-1:0] < r_g) begin
                    n_state = S_LOOP;
                end else if (r_cell == {r_gr, r_gc}) begin
                    n_len = r_cost_rd[CostW-1:0] + CostW'(1);
                    n_k   = r_cost_rd[CellW-1:0];
                    n_cur = r_cell;
                    n_state = (r_cost_rd[CostW-1:0] >= CostW'(Cells)) ? S_OUT : S_BP;
                end else begin
                    n_d     = DIR_UP;
                    n_state = S_NB;
                end
            end
            S_NB: begin
                n_n = nn;
                if (nb_ok) begin
                    n_state = S_NB2;
                end else if (r_d == DIR_RIGHT) begin
                    n_state = S_LOOP;
                end else begin
                    n_d = r_d + 2'd1;
                end
            end
            S_NB2: begin
                n_state = S_PUSHW;
                if (!r_blk_rd && (!r_cost_rd[CostW] || ng < r_cost_rd[CostW-1:0])) begin
                    if (hstat.count >= HCntW'(HeapDepth)) begin
                        n_state = S_OUT;
                    end else begin
                        cost_we   = 1'b1;
                        cost_wa   = r_n;
                        cost_wd   = {1'b1, ng};
                        came_we   = 1'b1;
                        hcmd.push = 1'b1;
                        hcmd.key  = {ng + CostW'(manh(r_n, r_gr, r_gc)), r_n};
                    end
                end
            end
            S_PUSHW: begin
                if (!hstat.busy) begin
                    if (r_d == DIR_RIGHT) begin
                        n_state = S_LOOP;
                    end else begin
                        n_d     = r_d + 2'd1;
                        n_state = S_NB;
                    end
                end
            end
            S_BP: begin
                path_we = 1'b1;
                if (r_k == '0) begin
                    n_found  = 1'b1;
                    n_length = r_len;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_BP2;
                end
            end
            S_BP2: begin
                n_k     = r_k - CellW'(1);
                n_state = S_BP;
                case (r_came_rd)
                    DIR_UP: begin
                        n_cur = {pr + CoordW'(1), pc};
                        if (pr == '1) n_state = S_OUT;
                    end
                    DIR_DOWN: begin
                        n_cur = {pr - CoordW'(1), pc};
                        if (pr == '0) n_state = S_OUT;
                    end
                    DIR_LEFT: begin
                        n_cur = {pr, pc + CoordW'(1)};
                        if (pc == '1) n_state = S_OUT;
                    end
                    default: begin
                        n_cur = {pr, pc - CoordW'(1)};
                        if (pc == '0) n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_of    = r_found;
                    n_olen  = r_length;
                    n_oev   = r_ev;
                    n_orow  = r_ev ? r_path_rd[CellW-1:CoordW] : '0;
                    n_ocol  = r_ev ? r_path_rd[CoordW-1:0] : '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.found       = r_of;
    assign o_out.path_length = r_olen;
    assign o_out.entry_valid = r_oev;
    assign o_out.path_row    = r_orow;
    assign o_out.path_col    = r_ocol;

endmodule

// ===== tb/grid_astar_path_search_tb.sv =====
module grid_astar_path_search_tb;
    import gaps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0] func;
        logic [4:0] cr, cc;
        logic       blk;
        logic [4:0] sr, sc, gr, gc;
        logic [9:0] pidx;
    } t_req;

    typedef struct {
        logic        found;
        logic [10:0] plen;
        logic        ev;
        logic [4:0]  prow, pcol;
    } t_rsp;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic i_cfg_idx = CFG_ROWS;
    logic [DimW-1:0] i_cfg_data = '0;

    gaps_in_if in_ch();
    gaps_out_if out_ch();

    grid_astar_path_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [5:0]  m_rows = 32, m_cols = 32;
    bit          m_blk[Cells];
    int          m_cost[Cells];
    bit          m_seen[Cells];
    int          m_dir[Cells];
    longint      m_heap[$];
    int          m_path[Cells];
    int          m_len = 0;
    bit          m_found = 0;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   idle_cnt = 0;
    int   wd = 0;
    bit   in_taken = 0;

    function automatic int edim(logic [5:0] v);
        if (v == 0) return 1;
        if (v > MaxDim) return MaxDim;
        return v;
    endfunction

    function automatic int adiff(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic longint pop_min();
        int bi = 0;
        longint v;
        for (int i = 1; i < m_heap.size(); i++)
            if (m_heap[i] < m_heap[bi]) bi = i;
        v = m_heap[bi];
        m_heap.delete(bi);
        return v;
    endfunction

    function automatic void trace_path(int goal);
        int len, cur, d, r, c;
        len = m_cost[goal] + 1;
        cur = goal;
        if (len > Cells) return;
        for (int k = len - 1; k >= 0; k--) begin
            m_path[k] = cur;
            if (k > 0) begin
                d = m_dir[cur];
                r = cur / MaxDim - (d == DIR_UP ? -1 : d == DIR_DOWN ? 1 : 0);
                c = cur % MaxDim - (d == DIR_LEFT ? -1 : d == DIR_RIGHT ? 1 : 0);
                if (r < 0 || c < 0 || r >= MaxDim || c >= MaxDim) return;
                cur = r * MaxDim + c;
            end
        end
        m_len = len;
        m_found = 1;
    endfunction

    function automatic void search_grid(int sr, int sc, int gr, int gc);
        int rows, cols, s, goal, node, f, r, c, h, g, nr, nc, n, ng;
        longint key;
        rows = edim(m_rows);
        cols = edim(m_cols);
        m_found = 0;
        m_len = 0;
        if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return;
        foreach (m_seen[i]) m_seen[i] = 0;
        m_heap.delete();
        s = sr * MaxDim + sc;
        goal = gr * MaxDim + gc;
        m_cost[s] = 0;
        m_seen[s] = 1;
        m_heap.insert(m_heap.size(), longint'(adiff(sr, gr) + adiff(sc, gc)) * Cells + s);
        while (m_heap.size() > 0) begin
            key = pop_min();
            node = int'(key % Cells);
            f = int'(key / Cells);
            r = node / MaxDim;
            c = node % MaxDim;
            h = adiff(r, gr) + adiff(c, gc);
            g = f >= h ? f - h : 0;
            if (m_cost[node] < g) continue;
            if (node == goal) begin
                trace_path(goal);
                return;
            end
            for (int d = 0; d < 4; d++) begin
                nr = r + (d == DIR_UP ? -1 : d == DIR_DOWN ? 1 : 0);
                nc = c + (d == DIR_LEFT ? -1 : d == DIR_RIGHT ? 1 : 0);
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                n = nr * MaxDim + nc;
                if (m_blk[n]) continue;
                ng = g + 1;
                if (!m_seen[n] || ng < m_cost[n]) begin
                    m_cost[n] = ng;
                    m_seen[n] = 1;
                    m_dir[n] = d;
                    if (m_heap.size() >= HeapDepth) return;
                    m_heap.insert(m_heap.size(),
                                  longint'(ng + adiff(nr, gr) + adiff(nc, gc)) * Cells + n);
                end
            end
        end
    endfunction

    function automatic t_rsp predict_rsp(t_req q);
        t_rsp e;
        e.ev = 1'b0;
        e.prow = '0;
        e.pcol = '0;
        if (q.func == FUNC_WRITE) begin
            m_blk[q.cr * MaxDim + q.cc] = q.blk;
        end else if (q.func == FUNC_SEARCH) begin
            search_grid(q.sr, q.sc, q.gr, q.gc);
        end else if (q.func == FUNC_READ) begin
            if (q.pidx < m_len) begin
                e.ev = 1'b1;
                e.prow = 5'(m_path[q.pidx] / MaxDim);
                e.pcol = 5'(m_path[q.pidx] % MaxDim);
            end
        end
        e.found = m_found;
        e.plen = 11'(m_len);
        return e;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
        end else if (!in_ch.valid || in_taken) begin
            if (in_taken) idle_cnt = $urandom_range(0, 7) * $urandom_range(0, 1);
            in_taken = 0;
            if (idle_cnt > 0) begin
                idle_cnt--;
                in_ch.valid <= 0;
            end else if (pending_reqs.size() > 0) begin
                t_req q;
                q = pending_reqs.pop_front();
                in_ch.valid <= 1;
                in_ch.func <= q.func;
                in_ch.cell_row <= q.cr;
                in_ch.cell_col <= q.cc;
                in_ch.blocked <= q.blk;
                in_ch.start_row <= q.sr;
                in_ch.start_col <= q.sc;
                in_ch.goal_row <= q.gr;
                in_ch.goal_col <= q.gc;
                in_ch.path_index <= q.pidx;
            end else begin
                in_ch.valid <= 0;
            end
        end
    end

    // response stall
    int stall_cnt = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else begin
            if (stall_cnt == 0) begin
                stall_cnt = $urandom_range(0, 7) * $urandom_range(0, 1);
                out_ch.ready <= (stall_cnt == 0);
            end else begin
                stall_cnt--;
                out_ch.ready <= (stall_cnt == 0);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            wd++;
            if (in_ch.valid && in_ch.ready) begin
                t_req q;
                q.func = in_ch.func; q.cr = in_ch.cell_row; q.cc = in_ch.cell_col;
                q.blk = in_ch.blocked; q.sr = in_ch.start_row; q.sc = in_ch.start_col;
                q.gr = in_ch.goal_row; q.gc = in_ch.goal_col; q.pidx = in_ch.path_index;
                expected_rsps.insert(expected_rsps.size(), predict_rsp(q));
                in_taken = 1;
                wd = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                t_rsp e;
                wd = 0;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response", $realtime);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (out_ch.found !== e.found || out_ch.path_length !== e.plen ||
                        out_ch.entry_valid !== e.ev || out_ch.path_row !== e.prow ||
                        out_ch.path_col !== e.pcol) begin
                        $display("%0t: exp f%0d l%0d v%0d r%0d c%0d got f%0d l%0d v%0d r%0d c%0d",
                                 $realtime, e.found, e.plen, e.ev, e.prow, e.pcol,
                                 out_ch.found, out_ch.path_length, out_ch.entry_valid,
                                 out_ch.path_row, out_ch.path_col);
                        errors++;
                    end
                end
            end
            if (wd > 1000000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic t_req mk(logic [1:0] f);
        t_req q;
        q.func = f;
        q.cr = 5'($urandom); q.cc = 5'($urandom); q.blk = 1'($urandom);
        q.sr = 5'($urandom); q.sc = 5'($urandom); q.gr = 5'($urandom); q.gc = 5'($urandom);
        q.pidx = 10'($urandom);
        return q;
    endfunction

    task automatic enqueue(t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic add_write(int r, int c, bit b);
        t_req q;
        q = mk(FUNC_WRITE);
        q.cr = 5'(r); q.cc = 5'(c); q.blk = b;
        enqueue(q);
    endtask

    task automatic add_search(int sr, int sc, int gr, int gc);
        t_req q;
        q = mk(FUNC_SEARCH);
        q.sr = 5'(sr); q.sc = 5'(sc); q.gr = 5'(gr); q.gc = 5'(gc);
        enqueue(q);
    endtask

    task automatic add_read(int idx);
        t_req q;
        q = mk(FUNC_READ);
        q.pidx = 10'(idx);
        enqueue(q);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_dim(logic idx, logic [5:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_ROWS) m_rows = v; else m_cols = v;
    endtask

    task automatic random_phase(int n, int dim);
        int lim;
        lim = dim > 32 ? 31 : dim - 1;
        for (int i = 0; i < n; i++) begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 50) add_write($urandom_range(0, lim), $urandom_range(0, lim),
                                  $urandom_range(0, 3) == 0);
            else if (k < 62) add_search($urandom_range(0, lim), $urandom_range(0, lim),
                                        $urandom_range(0, lim), $urandom_range(0, lim));
            else if (k < 64) enqueue(mk(2'($urandom_range(0, 3))));
            else add_read($urandom_range(0, 40) == 0 ? $urandom : $urandom_range(0, 2 * lim));
        end
    endtask

    initial begin
        in_ch.valid = 0;
        in_ch.func = FUNC_WRITE; in_ch.cell_row = 0; in_ch.cell_col = 0; in_ch.blocked = 0;
        in_ch.start_row = 0; in_ch.start_col = 0; in_ch.goal_row = 0; in_ch.goal_col = 0;
        in_ch.path_index = 0;
        out_ch.ready = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        add_read(0);
        add_search(0, 0, 31, 31);
        add_read(0); add_read(62); add_read(63); add_read(1023);
        add_search(5, 5, 5, 5);
        add_read(0);
        add_write(31, 31, 1);
        add_search(0, 0, 31, 31);
        add_write(0, 1, 1); add_write(1, 0, 1);
        add_search(0, 0, 3, 3);
        add_write(0, 0, 1);
        add_search(0, 0, 0, 0);
        add_search(31, 0, 0, 31);
        add_read(3);
        enqueue(mk(2'd3));
        add_write(31, 31, 0); add_write(0, 1, 0); add_write(1, 0, 0); add_write(0, 0, 0);
        drain();

        set_dim(CFG_ROWS, 4); set_dim(CFG_COLS, 1);
        add_search(0, 0, 3, 0); add_search(0, 0, 0, 1); add_search(3, 0, 4, 0);
        add_read(3);
        drain();
        set_dim(CFG_ROWS, 0); set_dim(CFG_COLS, 63);
        add_search(0, 0, 0, 31); add_read(31); add_search(1, 0, 0, 0);
        drain();

        set_dim(CFG_ROWS, 8); set_dim(CFG_COLS, 8);
        random_phase(500, 8);
        drain();
        set_dim(CFG_ROWS, 1); set_dim(CFG_COLS, 1);
        random_phase(60, 2);
        drain();
        set_dim(CFG_ROWS, 32); set_dim(CFG_COLS, 32);
        random_phase(300, 32);
        drain();
        set_dim(CFG_ROWS, 12); set_dim(CFG_COLS, 5);
        random_phase(500, 12);
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/gaps_pkg.sv
sv/gaps_in_if.sv
sv/gaps_out_if.sv
sv/gaps_heap.sv
sv/grid_astar_path_search.sv
tb/grid_astar_path_search_tb.sv
